/* hw/rtl/lif_neuron_array_tick_defines.svh */
// Assertion macros used by the neuron array controller.
`ifndef LIF_NEURON_ARRAY_TICK_DEFINES_SVH
`define LIF_NEURON_ARRAY_TICK_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define LIF_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define LIF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* hw/rtl/lif_pkg.sv */
// Shared types, register map and command codes of the neuron array.
package lif_pkg;

  localparam int NEURONS_DEF    = 32;
  localparam int VALUE_BITS_DEF = 32;
  localparam int PADDR_BITS     = 5;

  localparam logic [2:0] REG_MEMBRANE_SCALE   = 3'd0;
  localparam logic [2:0] REG_DENDRITE_SCALE   = 3'd1;
  localparam logic [2:0] REG_SYNAPSE_DECAY    = 3'd2;
  localparam logic [2:0] REG_FIRE_THRESHOLD   = 3'd3;
  localparam logic [2:0] REG_REST_LEVEL       = 3'd4;
  localparam logic [2:0] REG_REFRACTORY_TICKS = 3'd5;

  localparam logic [15:0] MEMBRANE_SCALE_RST   = 16'd6554;
  localparam logic [15:0] DENDRITE_SCALE_RST   = 16'd1311;
  localparam logic [15:0] SYNAPSE_DECAY_RST    = 16'd63918;
  localparam logic [31:0] FIRE_THRESHOLD_RST   = 32'd1677722;
  localparam logic [31:0] REST_LEVEL_RST       = 32'd0;
  localparam logic [15:0] REFRACTORY_TICKS_RST = 16'd40;

  typedef enum logic [1:0] {
    CMD_ADD_WEIGHT = 2'd0,
    CMD_TICK       = 2'd1,
    CMD_SET_BG     = 2'd2,
    CMD_SET_DEND   = 2'd3
  } cmd_t;

  typedef struct packed {
    logic [1:0]         cmd;
    logic [4:0]         neuron;
    logic signed [31:0] amount;
  } req_t;

  typedef struct packed {
    logic [4:0] spike_neuron;
    logic       spike_valid;
    logic       last;
  } rsp_t;

  typedef struct packed {
    logic [15:0]        membrane_scale;
    logic [15:0]        dendrite_scale;
    logic [15:0]        synapse_decay;
    logic signed [31:0] fire_threshold;
    logic signed [31:0] rest_level;
    logic [15:0]        refractory_ticks;
  } cfg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_CMD_WRITE,
    ST_READ,
    ST_MUL1,
    ST_MUL2,
    ST_MUL3,
    ST_WRITE,
    ST_LAST
  } state_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic load;
    logic rd_en;
    logic mul1;
    logic mul2;
    logic mul3;
    logic tick_wr;
    logic op_wr;
    logic emit_spike;
    logic emit_last;
  } ctl_t;

  // Datapath to controller status.
  typedef struct packed {
    logic is_tick;
    logic in_range;
    logic spike;
    logic out_free;
  } sts_t;

endpackage

/* hw/rtl/lif_neuron_array_tick.sv */
// Top level of the leaky integrate-and-fire neuron array.
// Holds NEURONS leaky integrate-and-fire neurons with signed Q8.24 state in VALUE_BITS bits
// and unsigned Q0.16 scale factors set over the APB port. A request transaction carries a
// command: add a synaptic weight to one neuron's AMPA conductance (saturating), set its
// background current, set its dendrite background current, or tick. Commands naming a
// neuron beyond the array are dropped without result. A tick walks the neurons in index
// order, each through a state read, three multiply steps and a write-back.
// Each spike gives one response transaction with spike_valid set; the tick closes with one
// end marker with last set. A single output register parts the two sides; a stalled response
// holds the walk at the write-back of the next spiking neuron. Neuron state lives in a small
// memory with one valid bit per row, so reset takes effect with no clearing pass;
// an unwritten row reads as zero.
module lif_neuron_array_tick import lif_pkg::*; #(
  parameter int NEURONS    = NEURONS_DEF,
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  // configuration port
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [PADDR_BITS-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready,
  // command channel
  input  logic                  req_valid,
  output logic                  req_ready,
  input  req_t                  req,
  // spike channel
  output logic                  rsp_valid,
  input  logic                  rsp_ready,
  output rsp_t                  rsp
);

  localparam int IW = (NEURONS > 1) ? $clog2(NEURONS) : 1;

  cfg_t          cfg;
  ctl_t          ctl;
  sts_t          sts;
  logic [IW-1:0] idx;

  // Register file: scale factors, threshold, rest level, refractory period.
  lif_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Controller: decode the transaction, step the neuron index, pace the result register.
  lif_ctrl #(
    .NEURONS (NEURONS)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .sts       (sts),
    .ctl       (ctl),
    .idx       (idx)
  );

  // Datapath: state rows, the update arithmetic and the output register.
  lif_dp #(
    .NEURONS    (NEURONS),
    .VALUE_BITS (VALUE_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .req       (req),
    .ctl       (ctl),
    .idx       (idx),
    .sts       (sts),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

endmodule

/* hw/rtl/lif_regs.sv */
// APB configuration register file of the neuron array.
module lif_regs import lif_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [PADDR_BITS-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready,
  output cfg_t                  cfg
);

  logic [2:0] reg_idx;
  logic       wr_en;

  assign reg_idx = paddr[4:2];
  assign wr_en   = psel & penable & pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.membrane_scale   <= MEMBRANE_SCALE_RST;
      cfg.dendrite_scale   <= DENDRITE_SCALE_RST;
      cfg.synapse_decay    <= SYNAPSE_DECAY_RST;
      cfg.fire_threshold   <= FIRE_THRESHOLD_RST;
      cfg.rest_level       <= REST_LEVEL_RST;
      cfg.refractory_ticks <= REFRACTORY_TICKS_RST;
    end else if (wr_en) begin
      case (reg_idx)
        REG_MEMBRANE_SCALE:   cfg.membrane_scale   <= pwdata[15:0];
        REG_DENDRITE_SCALE:   cfg.dendrite_scale   <= pwdata[15:0];
        REG_SYNAPSE_DECAY:    cfg.synapse_decay    <= pwdata[15:0];
        REG_FIRE_THRESHOLD:   cfg.fire_threshold   <= pwdata;
        REG_REST_LEVEL:       cfg.rest_level       <= pwdata;
        REG_REFRACTORY_TICKS: cfg.refractory_ticks <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_MEMBRANE_SCALE:   prdata = {16'd0, cfg.membrane_scale};
      REG_DENDRITE_SCALE:   prdata = {16'd0, cfg.dendrite_scale};
      REG_SYNAPSE_DECAY:    prdata = {16'd0, cfg.synapse_decay};
      REG_FIRE_THRESHOLD:   prdata = cfg.fire_threshold;
      REG_REST_LEVEL:       prdata = cfg.rest_level;
      REG_REFRACTORY_TICKS: prdata = {16'd0, cfg.refractory_ticks};
      default:              prdata = 32'd0;
    endcase
  end

endmodule

/* hw/rtl/lif_dp.sv */
// Datapath: neuron state memory, fixed-point update arithmetic, result register.
module lif_dp import lif_pkg::*; #(
  parameter  int NEURONS    = NEURONS_DEF,
  parameter  int VALUE_BITS = VALUE_BITS_DEF,
  localparam int IW         = (NEURONS > 1) ? $clog2(NEURONS) : 1
) (
  input  logic          clk,
  input  logic          rst,
  input  cfg_t          cfg,
  input  req_t          req,
  input  ctl_t          ctl,
  input  logic [IW-1:0] idx,
  output sts_t          sts,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  output rsp_t          rsp
);

  localparam int VB = VALUE_BITS;
  localparam int PW = VB + 17;
  localparam int SW = VB + 2;
  localparam int XW = ((VB > 32) ? VB : 32) + 1;

  localparam logic signed [SW-1:0] SMAX = {3'b000, {(VB-1){1'b1}}};
  localparam logic signed [SW-1:0] SMIN = {3'b111, {(VB-1){1'b0}}};
  localparam logic signed [XW-1:0] XMAX = {{(XW-VB+1){1'b0}}, {(VB-1){1'b1}}};
  localparam logic signed [XW-1:0] XMIN = {{(XW-VB+1){1'b1}}, {(VB-1){1'b0}}};

  typedef struct packed {
    logic signed [VB-1:0] mem;
    logic signed [VB-1:0] den;
    logic signed [VB-1:0] ampa;
    logic signed [VB-1:0] bg;
    logic signed [VB-1:0] db;
    logic [15:0]          refr;
  } row_t;

  function automatic logic signed [SW-1:0] ext2(input logic signed [VB-1:0] v);
    ext2 = {{2{v[VB-1]}}, v};
  endfunction

  function automatic logic signed [VB-1:0] sat2(input logic signed [SW-1:0] x);
    if (x > SMAX) sat2 = SMAX[VB-1:0];
    else if (x < SMIN) sat2 = SMIN[VB-1:0];
    else sat2 = x[VB-1:0];
  endfunction

  // Sign-extend or clamp a 32-bit value into the value range.
  function automatic logic signed [VB-1:0] fit32(input logic signed [31:0] a);
    logic signed [XW-1:0] x;
    x = {{(XW-32){a[31]}}, a};
    if (x > XMAX) fit32 = XMAX[VB-1:0];
    else if (x < XMIN) fit32 = XMIN[VB-1:0];
    else fit32 = x[VB-1:0];
  endfunction

  function automatic logic signed [PW-1:0] mulq(input logic [15:0] s,
                                                 input logic signed [VB-1:0] v);
    logic signed [16:0] ss;
    ss = $signed({1'b0, s});
    mulq = ss * v;
  endfunction

  // Round half up and drop sixteen fraction bits.
  function automatic logic signed [VB-1:0] rnd(input logic signed [PW-1:0] p);
    logic signed [PW-1:0] q;
    q = p + $signed(PW'(32768));
    rnd = q[VB+15:16];
  endfunction

  row_t                 mem_q [NEURONS];
  logic [NEURONS-1:0]   row_valid;
  row_t                 rd_row;
  logic                 rd_ok;
  row_t                 row;
  row_t                 wr_row;
  row_t                 op_row;
  row_t                 tick_row;
  logic                 wr_en;
  logic [IW-1:0]        addr;

  logic [1:0]           op;
  logic [4:0]           nrn;
  logic signed [VB-1:0] amt;

  logic signed [PW-1:0] p_ampa;
  logic signed [PW-1:0] p_e;
  logic signed [PW-1:0] p_d;
  logic signed [VB-1:0] e_diff;
  logic signed [VB-1:0] d_drive;
  logic signed [VB-1:0] ampa_new;
  logic signed [VB-1:0] den_new;

  logic signed [VB-1:0] thr;
  logic signed [VB-1:0] rest;
  logic signed [VB-1:0] mem_a;
  logic [15:0]          ref_a;
  logic [16:0]          ref_sum;
  logic                 spike;

  // Latch the transaction.
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      op  <= req.cmd;
      nrn <= req.neuron;
      amt <= fit32(req.amount);
    end
  end

  assign sts.is_tick  = (op == CMD_TICK);
  assign sts.in_range = (7'(nrn) < 7'(NEURONS));
  assign addr         = sts.is_tick ? idx : IW'(nrn);
  assign wr_en        = ctl.tick_wr | ctl.op_wr;

  always_ff @(posedge clk) begin
    if (ctl.rd_en) begin
      rd_row <= mem_q[addr];
      rd_ok  <= row_valid[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_q[addr] <= wr_row;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= '0;
    end else if (wr_en) begin
      row_valid[addr] <= 1'b1;
    end
  end

  // Unwritten rows read as the all-zero reset state.
  assign row = rd_ok ? rd_row : '0;

  always_ff @(posedge clk) begin
    if (ctl.mul1) begin
      p_ampa <= mulq(cfg.synapse_decay, row.ampa);
      e_diff <= sat2(ext2(row.db) - ext2(row.den));
    end
    if (ctl.mul2) begin
      d_drive  <= sat2(ext2(row.bg) - ext2(row.mem) + ext2(rnd(p_ampa)));
      ampa_new <= rnd(p_ampa);
      p_e      <= mulq(cfg.dendrite_scale, e_diff);
    end
    if (ctl.mul3) begin
      p_d     <= mulq(cfg.membrane_scale, d_drive);
      den_new <= sat2(ext2(row.den) + ext2(rnd(p_e)));
    end
  end

  assign thr  = fit32(cfg.fire_threshold);
  assign rest = fit32(cfg.rest_level);

  always_comb begin
    mem_a = sat2(ext2(row.mem) + ext2(rnd(p_d)));
    ref_a = row.refr;
    if (ref_a != 16'd0) begin
      mem_a = rest;
      ref_a = ref_a - 16'd1;
    end
    spike   = (mem_a > thr);
    ref_sum = {1'b0, ref_a} + {1'b0, cfg.refractory_ticks};
    tick_row      = row;
    tick_row.den  = den_new;
    tick_row.ampa = ampa_new;
    tick_row.mem  = mem_a;
    tick_row.refr = ref_a;
    if (spike) begin
      tick_row.mem  = rest;
      tick_row.refr = ref_sum[16] ? 16'hFFFF : ref_sum[15:0];
    end
  end

  always_comb begin
    op_row = row;
    case (op)
      CMD_ADD_WEIGHT: op_row.ampa = sat2(ext2(row.ampa) + ext2(amt));
      CMD_SET_BG:     op_row.bg   = amt;
      CMD_SET_DEND:   op_row.db   = amt;
      default: ;
    endcase
  end

  assign wr_row       = ctl.tick_wr ? tick_row : op_row;
  assign sts.spike    = spike;
  assign sts.out_free = ~rsp_valid | rsp_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (ctl.emit_spike | ctl.emit_last) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.emit_spike) begin
      rsp.spike_neuron <= 5'(idx);
      rsp.spike_valid  <= 1'b1;
      rsp.last         <= 1'b0;
    end else if (ctl.emit_last) begin
      rsp.spike_neuron <= 5'd0;
      rsp.spike_valid  <= 1'b0;
      rsp.last         <= 1'b1;
    end
  end

endmodule

/* hw/rtl/lif_ctrl.sv */
// Controller: sequences commands and the per-neuron tick walk.
`include "lif_neuron_array_tick_defines.svh"

module lif_ctrl import lif_pkg::*; #(
  parameter  int NEURONS = NEURONS_DEF,
  localparam int IW      = (NEURONS > 1) ? $clog2(NEURONS) : 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  sts_t          sts,
  output ctl_t          ctl,
  output logic [IW-1:0] idx
);

  localparam logic [IW-1:0] LAST_IDX = IW'(NEURONS - 1);

  state_t        state;
  state_t        state_next;
  logic [IW-1:0] idx_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      idx   <= '0;
    end else begin
      state <= state_next;
      idx   <= idx_next;
    end
  end

  always_comb begin
    state_next = state;
    idx_next   = idx;
    ctl        = '0;
    req_ready  = 1'b0;
    case (state)
      ST_IDLE: begin
        req_ready = 1'b1;
        idx_next  = '0;
        if (req_valid) begin
          ctl.load   = 1'b1;
          state_next = ST_DECODE;
        end
      end
      ST_DECODE: begin
        ctl.rd_en = 1'b1;
        if (sts.is_tick) begin
          state_next = ST_MUL1;
        end else if (sts.in_range) begin
          state_next = ST_CMD_WRITE;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_CMD_WRITE: begin
        ctl.op_wr  = 1'b1;
        state_next = ST_IDLE;
      end
      ST_READ: begin
        ctl.rd_en  = 1'b1;
        state_next = ST_MUL1;
      end
      ST_MUL1: begin
        ctl.mul1   = 1'b1;
        state_next = ST_MUL2;
      end
      ST_MUL2: begin
        ctl.mul2   = 1'b1;
        state_next = ST_MUL3;
      end
      ST_MUL3: begin
        ctl.mul3   = 1'b1;
        state_next = ST_WRITE;
      end
      ST_WRITE: begin
        if (!sts.spike || sts.out_free) begin
          ctl.tick_wr    = 1'b1;
          ctl.emit_spike = sts.spike;
          if (idx == LAST_IDX) begin
            state_next = ST_LAST;
          end else begin
            idx_next   = idx + 1'b1;
            state_next = ST_READ;
          end
        end
      end
      ST_LAST: begin
        if (sts.out_free) begin
          ctl.emit_last = 1'b1;
          state_next    = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  `LIF_ASSERT_NOW(a_no_rw_clash, ctl.rd_en, !(ctl.tick_wr || ctl.op_wr), "row read and write clash")
  `LIF_ASSERT_NOW(a_emit_room, ctl.emit_spike || ctl.emit_last, sts.out_free, "result register overrun")
  `LIF_ASSERT_NEXT(a_last_idle, ctl.emit_last, state == ST_IDLE && req_ready, "no return to idle after end marker")
  `LIF_ASSERT_NOW(a_idx_range, state == ST_WRITE, idx <= LAST_IDX, "neuron index past array end")

endmodule
